FILE: hdl/cs2sph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2sph_pkg
// Shared constants, types and helper functions for the cartesian to
// cylindrical / spherical converter.
// ----------------------------------------------------------------------------
package cs2sph_pkg;

  // Default configuration of the top level
  localparam int ITERATIONS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  // Coordinates enter the rotators scaled by 2^PRESCALE
  localparam int PRESCALE  = 24;
  // Entries in the arctangent table
  localparam int TABLE_LEN = 24;
  // Rotator gain K = 1.6467602581 in Q30
  localparam logic [30:0] KGAIN_Q30 = 31'd1768195363;

  // Angle accumulator: signed, 2^31 equals pi
  localparam int ANG_W = 33;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 33'sd1073741824;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 33'sd2147483648;
  // Half an output LSB, added before dropping 16 fraction bits
  localparam logic signed [ANG_W-1:0] ANG_RND     = 33'sd32768;

  // Per-point classification flags
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic z_zero;
    logic z_neg;
  } pt_flags_t;

  // Flags needed by the polar fold
  typedef struct packed {
    logic xy_zero;
    logic z_zero;
    logic z_neg;
  } pol_flags_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [31:0] atan_step(input int unsigned idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

  // Clamp a first-quadrant angle to [0, pi/2]
  function automatic logic signed [ANG_W-1:0] clamp_angle(
    input logic signed [ANG_W-1:0] ang
  );
    logic signed [ANG_W-1:0] res;
    if (ang[ANG_W-1]) begin
      res = '0;
    end else if (ang > ANG_HALF_PI) begin
      res = ANG_HALF_PI;
    end else begin
      res = ang;
    end
    return res;
  endfunction

endpackage

FILE: hdl/cs2sph_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2sph_cordic
// Pipelined vectoring rotator, one micro-rotation per register stage. Drives
// the vector onto the x axis and accumulates the rotation angle. A side
// vector travels along with each point.
// ----------------------------------------------------------------------------
module cs2sph_cordic #(
  parameter int W      = 44,
  parameter int NSTEP  = 16,
  parameter int SIDE_W = 8
) (
  input  logic                                   clk,
  input  logic                                   ce,
  input  logic signed [W-1:0]                    vx_i,
  input  logic signed [W-1:0]                    vy_i,
  input  logic [SIDE_W-1:0]                      side_i,
  output logic signed [W-1:0]                    vx_o,
  output logic signed [cs2sph_pkg::ANG_W-1:0]    acc_o,
  output logic [SIDE_W-1:0]                      side_o
);

  localparam int AW = cs2sph_pkg::ANG_W;

  logic signed [W-1:0]  vx_r   [NSTEP];
  logic signed [W-1:0]  vy_r   [NSTEP];
  logic signed [AW-1:0] acc_r  [NSTEP];
  logic [SIDE_W-1:0]    side_r [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_stage
    localparam logic signed [AW-1:0] STEP = AW'(cs2sph_pkg::atan_step(i));

    logic signed [W-1:0]  px;
    logic signed [W-1:0]  py;
    logic signed [AW-1:0] pa;
    logic [SIDE_W-1:0]    ps;
    logic signed [W-1:0]  sx;
    logic signed [W-1:0]  sy;
    logic                 up;

    // Select the stage input
    if (i == 0) begin : g_first
      assign px = vx_i;
      assign py = vy_i;
      assign pa = '0;
      assign ps = side_i;
    end else begin : g_next
      assign px = vx_r[i-1];
      assign py = vy_r[i-1];
      assign pa = acc_r[i-1];
      assign ps = side_r[i-1];
    end

    // Shifts round toward minus infinity
    assign sx = px >>> i;
    assign sy = py >>> i;
    assign up = !py[W-1] && (py != '0);

    // Rotate toward the x axis
    always_ff @(posedge clk) begin
      if (ce) begin
        if (up) begin
          vx_r[i]  <= px + sy;
          vy_r[i]  <= py - sx;
          acc_r[i] <= pa + STEP;
        end else begin
          vx_r[i]  <= px - sy;
          vy_r[i]  <= py + sx;
          acc_r[i] <= pa - STEP;
        end
        side_r[i] <= ps;
      end
    end
  end

  assign vx_o   = vx_r[NSTEP-1];
  assign acc_o  = acc_r[NSTEP-1];
  assign side_o = side_r[NSTEP-1];

endmodule

FILE: hdl/cs2sph_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2sph_isqrt
// Pipelined integer square root, one root bit per stage, followed by a
// round-to-nearest stage: a remainder above the floor root rounds up.
// ----------------------------------------------------------------------------
module cs2sph_isqrt #(
  parameter int CB = 16
) (
  input  logic            clk,
  input  logic            ce,
  input  logic [2*CB-1:0] n_i,
  output logic [CB-1:0]   root_o
);

  logic [CB+1:0]   rem_r  [CB];
  logic [CB-1:0]   root_r [CB];
  logic [2*CB-1:0] n_r    [CB];
  logic [CB-1:0]   rnd_r;

  for (genvar k = 0; k < CB; k++) begin : g_stage
    logic [CB+1:0]   prem;
    logic [CB-1:0]   proot;
    logic [2*CB-1:0] pn;
    logic [CB+3:0]   part;
    logic [CB+3:0]   trial;

    // Select the stage input
    if (k == 0) begin : g_first
      assign prem  = '0;
      assign proot = '0;
      assign pn    = n_i;
    end else begin : g_next
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pn    = n_r[k-1];
    end

    // Bring down two bits and try the next root bit
    assign part  = {prem, pn[2*CB-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (ce) begin
        if (part >= trial) begin
          rem_r[k]  <= (CB+2)'(part - trial);
          root_r[k] <= {proot[CB-2:0], 1'b1};
        end else begin
          rem_r[k]  <= (CB+2)'(part);
          root_r[k] <= {proot[CB-2:0], 1'b0};
        end
        n_r[k] <= {pn[2*CB-3:0], 2'b00};
      end
    end
  end

  // Round to nearest
  always_ff @(posedge clk) begin
    if (ce) begin
      rnd_r <= root_r[CB-1] + CB'(rem_r[CB-1] > {2'b00, root_r[CB-1]});
    end
  end

  assign root_o = rnd_r;

endmodule

FILE: hdl/cartesian_to_spherical_convert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical_convert_core
// Converts a signed cartesian point to planar radius, azimuth, full radius
// and polar angle.
// ----------------------------------------------------------------------------
// Takes one point per clock while in_tready is high and returns one result
// per point, in order. The two chained rotator pipelines (one stage per
// iteration each) and the bit-per-stage square root run in parallel, and the
// shorter of the two paths is delayed to match the longer. The pipeline keeps
// filling while a result waits on out_tready, until the last stage holds an
// item. Radii are rounded to nearest; angles are binary angles with
// 32768 = pi, the azimuth signed (pi reads as -32768), the polar angle
// unsigned in [0, 32768].
// ----------------------------------------------------------------------------
module cartesian_to_spherical_convert_core #(
  parameter int ITERATIONS = cs2sph_pkg::ITERATIONS_DEF,
  parameter int COORD_BITS = cs2sph_pkg::COORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // x_coord, y_coord, z_coord (from bit 0 up), zero padded to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]            in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // planar_radius, azimuth, full_radius, polar_angle (from bit 0 up)
  output logic [((2*COORD_BITS+32+7)/8)*8-1:0]         out_tdata
);

  localparam int CB       = COORD_BITS;
  localparam int NSTEP    = (ITERATIONS > cs2sph_pkg::TABLE_LEN) ?
                            cs2sph_pkg::TABLE_LEN : ITERATIONS;
  localparam int PS       = cs2sph_pkg::PRESCALE;
  localparam int AW       = cs2sph_pkg::ANG_W;
  localparam int W        = CB + PS + 4;
  localparam int SQ_W     = 2 * CB;
  localparam int OUT_W    = ((2*CB+32+7)/8)*8;
  localparam int RES_W    = 2*CB + 32;
  localparam int LAT_RAD  = CB + 4;
  localparam int LAT_ANG  = 2*NSTEP + 3;
  localparam int LAT      = (LAT_RAD > LAT_ANG) ? LAT_RAD : LAT_ANG;
  localparam int DLY_RAD  = LAT - LAT_RAD;
  localparam int DLY_ANG  = LAT - LAT_ANG;
  localparam int FLG_W    = $bits(cs2sph_pkg::pt_flags_t);
  localparam int PFLG_W   = $bits(cs2sph_pkg::pol_flags_t);
  localparam int SIDE1_W  = CB + FLG_W;
  localparam int SIDE2_W  = AW + PFLG_W;
  localparam int KPROD_W  = CB + 31;

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  logic             pipe_ce;
  logic [LAT-1:0]   vld_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [RES_W-1:0] res_nxt;

  // Advance while the last stage is empty or can move into the output register
  assign pipe_ce   = !vld_r[LAT-1] || !out_valid_r || out_tready;
  assign in_tready = pipe_ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_ce) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: magnitudes, squares, flags
  // --------------------------------------------------------------------------
  logic signed [CB-1:0]   x_in;
  logic signed [CB-1:0]   y_in;
  logic signed [CB-1:0]   z_in;
  logic signed [SQ_W-1:0] x_sq;
  logic signed [SQ_W-1:0] y_sq;
  logic signed [SQ_W-1:0] z_sq;
  cs2sph_pkg::pt_flags_t  flg_nxt;

  logic [CB-1:0]          a_ax_r;
  logic [CB-1:0]          a_ay_r;
  logic [CB-1:0]          a_az_r;
  logic [SQ_W-1:0]        a_x2_r;
  logic [SQ_W-1:0]        a_y2_r;
  logic [SQ_W-1:0]        a_z2_r;
  cs2sph_pkg::pt_flags_t  a_flg_r;

  assign x_in = in_tdata[CB-1:0];
  assign y_in = in_tdata[2*CB-1:CB];
  assign z_in = in_tdata[3*CB-1:2*CB];
  assign x_sq = SQ_W'(x_in) * SQ_W'(x_in);
  assign y_sq = SQ_W'(y_in) * SQ_W'(y_in);
  assign z_sq = SQ_W'(z_in) * SQ_W'(z_in);

  always_comb begin
    flg_nxt.x_zero = (x_in == '0);
    flg_nxt.y_zero = (y_in == '0);
    flg_nxt.x_neg  = x_in[CB-1];
    flg_nxt.y_neg  = y_in[CB-1];
    flg_nxt.z_zero = (z_in == '0);
    flg_nxt.z_neg  = z_in[CB-1];
  end

  always_ff @(posedge clk) begin
    if (pipe_ce) begin
      a_ax_r  <= x_in[CB-1] ? CB'(-x_in) : CB'(x_in);
      a_ay_r  <= y_in[CB-1] ? CB'(-y_in) : CB'(y_in);
      a_az_r  <= z_in[CB-1] ? CB'(-z_in) : CB'(z_in);
      a_x2_r  <= SQ_W'(x_sq);
      a_y2_r  <= SQ_W'(y_sq);
      a_z2_r  <= SQ_W'(z_sq);
      a_flg_r <= flg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Radius path: sums, square roots, delay
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0] b_plane_r;
  logic [SQ_W-1:0] b_z2_r;
  logic [SQ_W-1:0] c_plane_r;
  logic [SQ_W-1:0] c_full_r;
  logic [CB-1:0]   plane_rad;
  logic [CB-1:0]   full_rad;
  logic [2*CB-1:0] rad_out;

  always_ff @(posedge clk) begin
    if (pipe_ce) begin
      b_plane_r <= a_x2_r + a_y2_r;
      b_z2_r    <= a_z2_r;
      c_plane_r <= b_plane_r;
      c_full_r  <= b_plane_r + b_z2_r;
    end
  end

  cs2sph_isqrt #(.CB(CB)) u_sqrt_plane (
    .clk    (clk),
    .ce     (pipe_ce),
    .n_i    (c_plane_r),
    .root_o (plane_rad)
  );

  cs2sph_isqrt #(.CB(CB)) u_sqrt_full (
    .clk    (clk),
    .ce     (pipe_ce),
    .n_i    (c_full_r),
    .root_o (full_rad)
  );

  // Align radii with the angle path
  if (DLY_RAD == 0) begin : g_rad_nodly
    assign rad_out = {full_rad, plane_rad};
  end else begin : g_rad_dly
    logic [2*CB-1:0] rad_dly_r [DLY_RAD];
    always_ff @(posedge clk) begin
      if (pipe_ce) begin
        rad_dly_r[0] <= {full_rad, plane_rad};
        for (int d = 1; d < DLY_RAD; d++) begin
          rad_dly_r[d] <= rad_dly_r[d-1];
        end
      end
    end
    assign rad_out = rad_dly_r[DLY_RAD-1];
  end

  // --------------------------------------------------------------------------
  // Azimuth rotator on (|x|, |y|)
  // --------------------------------------------------------------------------
  logic signed [W-1:0]   c1_vx_in;
  logic signed [W-1:0]   c1_vy_in;
  logic signed [W-1:0]   c1_vx;
  logic signed [AW-1:0]  c1_acc;
  logic [SIDE1_W-1:0]    c1_side;
  logic [CB-1:0]         c1_az;
  cs2sph_pkg::pt_flags_t c1_flg;

  assign c1_vx_in = {{(W-CB-PS){1'b0}}, a_ax_r, {PS{1'b0}}};
  assign c1_vy_in = {{(W-CB-PS){1'b0}}, a_ay_r, {PS{1'b0}}};

  cs2sph_cordic #(.W(W), .NSTEP(NSTEP), .SIDE_W(SIDE1_W)) u_cordic_azim (
    .clk    (clk),
    .ce     (pipe_ce),
    .vx_i   (c1_vx_in),
    .vy_i   (c1_vy_in),
    .side_i ({a_az_r, a_flg_r}),
    .vx_o   (c1_vx),
    .acc_o  (c1_acc),
    .side_o (c1_side)
  );

  assign c1_az  = c1_side[SIDE1_W-1:FLG_W];
  assign c1_flg = c1_side[FLG_W-1:0];

  // --------------------------------------------------------------------------
  // Stage M: fold azimuth into its quadrant, scale |z| by the gain
  // --------------------------------------------------------------------------
  logic signed [AW-1:0]   azq;
  logic signed [AW-1:0]   azh;
  logic signed [AW-1:0]   az_nxt;
  logic [KPROD_W-1:0]     kz_prod;
  cs2sph_pkg::pol_flags_t pflg_nxt;

  logic signed [W-1:0]    m_kz_r;
  logic signed [W-1:0]    m_rho_r;
  logic signed [AW-1:0]   m_az_r;
  cs2sph_pkg::pol_flags_t m_pflg_r;

  always_comb begin
    azq = cs2sph_pkg::clamp_angle(c1_acc);
    if (c1_flg.y_zero) begin
      azq = '0;
    end else if (c1_flg.x_zero) begin
      azq = cs2sph_pkg::ANG_HALF_PI;
    end
    azh    = c1_flg.x_neg ? (cs2sph_pkg::ANG_PI - azq) : azq;
    az_nxt = c1_flg.y_neg ? -azh : azh;
    pflg_nxt.xy_zero = c1_flg.x_zero && c1_flg.y_zero;
    pflg_nxt.z_zero  = c1_flg.z_zero;
    pflg_nxt.z_neg   = c1_flg.z_neg;
  end

  assign kz_prod = KPROD_W'(c1_az) * KPROD_W'(cs2sph_pkg::KGAIN_Q30);

  always_ff @(posedge clk) begin
    if (pipe_ce) begin
      m_kz_r   <= W'(kz_prod >> (30 - PS));
      m_rho_r  <= c1_vx;
      m_az_r   <= az_nxt;
      m_pflg_r <= pflg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Polar rotator on (K*|z|, K*rho)
  // --------------------------------------------------------------------------
  logic signed [AW-1:0]   c2_acc;
  logic [SIDE2_W-1:0]     c2_side;
  logic signed [AW-1:0]   c2_az;
  cs2sph_pkg::pol_flags_t c2_pflg;

  cs2sph_cordic #(.W(W), .NSTEP(NSTEP), .SIDE_W(SIDE2_W)) u_cordic_polar (
    .clk    (clk),
    .ce     (pipe_ce),
    .vx_i   (m_kz_r),
    .vy_i   (m_rho_r),
    .side_i ({m_az_r, m_pflg_r}),
    .vx_o   (),
    .acc_o  (c2_acc),
    .side_o (c2_side)
  );

  assign c2_az   = c2_side[SIDE2_W-1:PFLG_W];
  assign c2_pflg = c2_side[PFLG_W-1:0];

  // --------------------------------------------------------------------------
  // Stage F: fold polar angle, round both angles to 16 bits
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] polq;
  logic signed [AW-1:0] pol_fold;
  logic signed [AW-1:0] az_sum;
  logic signed [AW-1:0] pol_sum;
  logic [15:0]          f_az_r;
  logic [15:0]          f_pol_r;
  logic [31:0]          ang_out;

  always_comb begin
    polq = cs2sph_pkg::clamp_angle(c2_acc);
    if (c2_pflg.xy_zero) begin
      polq = '0;
    end else if (c2_pflg.z_zero) begin
      polq = cs2sph_pkg::ANG_HALF_PI;
    end
    pol_fold = c2_pflg.z_neg ? (cs2sph_pkg::ANG_PI - polq) : polq;
  end

  assign az_sum  = c2_az + cs2sph_pkg::ANG_RND;
  assign pol_sum = pol_fold + cs2sph_pkg::ANG_RND;

  always_ff @(posedge clk) begin
    if (pipe_ce) begin
      f_az_r  <= az_sum[31:16];
      f_pol_r <= pol_sum[31:16];
    end
  end

  // Align angles with the radius path
  if (DLY_ANG == 0) begin : g_ang_nodly
    assign ang_out = {f_pol_r, f_az_r};
  end else begin : g_ang_dly
    logic [31:0] ang_dly_r [DLY_ANG];
    always_ff @(posedge clk) begin
      if (pipe_ce) begin
        ang_dly_r[0] <= {f_pol_r, f_az_r};
        for (int d = 1; d < DLY_ANG; d++) begin
          ang_dly_r[d] <= ang_dly_r[d-1];
        end
      end
    end
    assign ang_out = ang_dly_r[DLY_ANG-1];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  assign res_nxt = {ang_out[31:16], rad_out[2*CB-1:CB], ang_out[15:0], rad_out[CB-1:0]};

  // Load the finished item, drop the held one once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_ce && vld_r[LAT-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ce && vld_r[LAT-1]) begin
      out_data_r <= OUT_W'(res_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*CB+31:2*CB+16] <= 16'h8000))
    else $error("polar angle above pi");

  a_radius_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*CB+15:CB+16] >= out_tdata[CB-1:0]))
    else $error("full radius below planar radius");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_ce && vld_r[LAT-1]) |=> vld_r[LAT-1])
    else $error("stalled item lost from last stage");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted point not marked valid");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[LAT-1]))
    else $error("result without a finished item");

endmodule

FILE: tb/spherical_result_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_result_monitor
// Watches the point and result streams of the converter. It computes the
// expected planar radius, azimuth, full radius and polar angle of every
// accepted point with its own integer square root and vectoring rotators.
// Each returned result is compared field by field, in order.
// ----------------------------------------------------------------------------
module spherical_result_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // x_coord, y_coord, z_coord (from bit 0 up)
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // planar_radius, azimuth, full_radius, polar_angle (from bit 0 up)
  input  logic [63:0] out_tdata,
  output int          error_count,
  output int          pending_count,
  output int          checked_count
);

  localparam int     ROT_STEPS = (cs2sph_pkg::ITERATIONS_DEF < cs2sph_pkg::TABLE_LEN) ?
                                 cs2sph_pkg::ITERATIONS_DEF : cs2sph_pkg::TABLE_LEN;
  localparam int     SCALE_SH  = cs2sph_pkg::PRESCALE;
  localparam longint GAIN_Q30  = 64'sd1768195363;
  localparam longint QUARTER   = 64'sd1073741824;
  localparam longint HALF_TURN = 64'sd2147483648;

  // Arctangent of 2^-i, 2^31 = pi
  localparam longint ATAN_LUT [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // First member sits in the top bits, so this matches the result tdata
  typedef struct packed {
    logic [15:0]        polar_angle;
    logic [15:0]        full_radius;
    logic signed [15:0] azimuth;
    logic [15:0]        planar_radius;
  } sph_point_t;

  sph_point_t results_due[$];

  // Integer square root, rounded to nearest
  function automatic longint unsigned root_nearest(input longint unsigned n);
    longint unsigned rem, root, probe;
    rem   = n;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  // Vector a first-quadrant pair onto the x axis; return the clamped angle
  function automatic longint vector_angle(input longint vx_in, input longint vy_in,
                                          output longint mag);
    longint vx, vy, nx, ny, acc;
    int     i;
    vx  = vx_in;
    vy  = vy_in;
    acc = 0;
    for (i = 0; i < ROT_STEPS; i++) begin
      if (vy > 0) begin
        nx  = vx + (vy >>> i);
        ny  = vy - (vx >>> i);
        acc = acc + ATAN_LUT[i];
      end else begin
        nx  = vx - (vy >>> i);
        ny  = vy + (vx >>> i);
        acc = acc - ATAN_LUT[i];
      end
      vx = nx;
      vy = ny;
    end
    mag = vx;
    if (acc < 0) acc = 0;
    if (acc > QUARTER) acc = QUARTER;
    return acc;
  endfunction

  function automatic sph_point_t convert_point(input logic signed [15:0] x_c,
                                               input logic signed [15:0] y_c,
                                               input logic signed [15:0] z_c);
    sph_point_t      res;
    longint          sx, sy, sz, ax, ay, az, rho_k, spare, az_ang, pol_ang, kz;
    longint          az_code, pol_code;
    longint unsigned plane_sq, full_sq, r_plane, r_full;
    sx = longint'(x_c);
    sy = longint'(y_c);
    sz = longint'(z_c);
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    plane_sq = ax * ax + ay * ay;
    full_sq  = plane_sq + az * az;

    // Azimuth: fold the first-quadrant angle by the signs of x and y
    az_ang = vector_angle(ax <<< SCALE_SH, ay <<< SCALE_SH, rho_k);
    if (sy == 0) az_ang = 0;
    else if (sx == 0) az_ang = QUARTER;
    if (sx < 0) az_ang = HALF_TURN - az_ang;
    if (sy < 0) az_ang = -az_ang;

    // Polar angle: rotate (K*|z|, K*rho) and fold by the sign of z
    kz      = (az * GAIN_Q30) >>> (30 - SCALE_SH);
    pol_ang = vector_angle(kz, rho_k, spare);
    if (sx == 0 && sy == 0) pol_ang = 0;
    else if (sz == 0) pol_ang = QUARTER;
    if (sz < 0) pol_ang = HALF_TURN - pol_ang;

    r_plane  = root_nearest(plane_sq);
    r_full   = root_nearest(full_sq);
    az_code  = (az_ang + 32768) >>> 16;
    pol_code = (pol_ang + 32768) >>> 16;
    res.planar_radius = r_plane[15:0];
    res.azimuth       = az_code[15:0];
    res.full_radius   = r_full[15:0];
    res.polar_angle   = pol_code[15:0];
    return res;
  endfunction

  // Predict on every point transfer, compare on every result transfer
  always @(posedge clk) begin
    sph_point_t want, got;
    int         errs;
    if (!rst_n) begin
      results_due.delete();
      error_count   <= 0;
      pending_count <= 0;
      checked_count <= 0;
    end else begin
      errs = 0;
      if (in_tvalid && in_tready)
        results_due.push_back(convert_point(in_tdata[15:0], in_tdata[31:16],
                                            in_tdata[47:32]));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (results_due.size() == 0) begin
          $error("result transfer with no point outstanding: tdata %h", out_tdata);
          errs++;
        end else begin
          want = results_due.pop_front();
          if (got.planar_radius !== want.planar_radius) begin
            $error("planar_radius: expected %0d, actual %0d",
                   want.planar_radius, got.planar_radius);
            errs++;
          end
          if (got.azimuth !== want.azimuth) begin
            $error("azimuth: expected %0d, actual %0d", want.azimuth, got.azimuth);
            errs++;
          end
          if (got.full_radius !== want.full_radius) begin
            $error("full_radius: expected %0d, actual %0d",
                   want.full_radius, got.full_radius);
            errs++;
          end
          if (got.polar_angle !== want.polar_angle) begin
            $error("polar_angle: expected %0d, actual %0d",
                   want.polar_angle, got.polar_angle);
            errs++;
          end
        end
        checked_count <= checked_count + 1;
      end
      error_count   <= error_count + errs;
      pending_count <= results_due.size();
    end
  end

endmodule

FILE: tb/tb_cartesian_to_spherical_convert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_spherical_convert_core
// Stream testbench for the cartesian to spherical converter. It feeds
// directed points (origin, axes, extremes, the azimuth wrap) and then mixed
// random points, with random gaps on the input and random back-pressure on
// the output. A separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_cartesian_to_spherical_convert_core;

  localparam int RANDOM_POINTS = 1300;
  localparam int DRAIN_CYCLES  = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        steady = 1'b0;

  int error_count;
  int pending_count;
  int checked_count;
  int directed_sent;
  int random_sent;

  always #1 clk = ~clk;

  cartesian_to_spherical_convert_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  spherical_result_monitor monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Stall the result stream at random, except during the steady stretch
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 37);
  end

  // Present one point and hold it until the transfer
  task automatic send_point(input logic signed [15:0] x_c,
                            input logic signed [15:0] y_c,
                            input logic signed [15:0] z_c);
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z_c, y_c, x_c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Pick one random coordinate, drawn from the mode of this point
  function automatic logic signed [15:0] pick_coord(input int mode);
    logic [15:0] raw;
    logic signed [15:0] edges [0:5];
    edges = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    raw = 16'($urandom());
    case (mode)
      0:       return raw;
      1:       return 16'($signed($urandom_range(0, 64)) - 32);
      2:       return edges[3'($urandom_range(0, 5))];
      default: return $signed({{8{raw[15]}}, raw[7:0]});
    endcase
  endfunction

  // Directed points: origin, each axis, both signs, extremes, azimuth of pi
  int directed [0:21][0:2] = '{
    '{0, 0, 0},            '{0, 0, 100},           '{0, 0, -100},
    '{0, 0, 32767},        '{0, 0, -32768},        '{32767, 0, 0},
    '{-32768, 0, 0},       '{-1, 0, 5},            '{0, 32767, 0},
    '{0, -32768, 0},       '{0, 1, -1},            '{5, 5, 0},
    '{-7, 3, 0},           '{32767, 32767, 32767}, '{-32768, -32768, -32768},
    '{-32768, 32767, -32768}, '{32767, -32768, 32767}, '{1, 1, 1},
    '{-1, -1, -1},         '{3, 4, 12},            '{-300, 400, -1200},
    '{-32768, 0, 32767}
  };

  initial begin
    int kind, mode, drop_mask, mag, wait_cycles;
    logic signed [15:0] px, py, pz;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_sent = 0;
    foreach (directed[i]) begin
      send_point(16'(directed[i][0]), 16'(directed[i][1]), 16'(directed[i][2]));
      directed_sent++;
    end

    random_sent = 0;
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      // Hold a stretch with no gaps and no stalls
      if (n == 400) steady <= 1'b1;
      if (n == 700) steady <= 1'b0;
      kind = $urandom_range(0, 9);
      if (kind < 5) mode = 0;
      else if (kind < 7) mode = 1;
      else if (kind == 8) mode = 2;
      else mode = 3;
      px = pick_coord(mode);
      py = pick_coord(mode);
      pz = pick_coord(mode);
      // Zero one or two coordinates to land on axes and planes
      if (kind == 7) begin
        drop_mask = $urandom_range(1, 6);
        if (drop_mask[0]) px = '0;
        if (drop_mask[1]) py = '0;
        if (drop_mask[2]) pz = '0;
      end
      // Diagonals: equal magnitudes with random signs
      if (kind == 9) begin
        mag = $urandom_range(0, 32767);
        px  = 16'($urandom_range(0, 1) ? mag : -mag);
        py  = 16'($urandom_range(0, 1) ? mag : -mag);
      end
      send_point(px, py, pz);
      random_sent++;
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    // Drain: wait for every result, then let the pipeline settle
    while (pending_count != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < DRAIN_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("Sent %0d directed points (origin, axes, extremes, azimuth wrap) and %0d random",
             directed_sent, random_sent);
    $display("points under random gaps and stalls; %0d results compared.", checked_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung stream
  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", pending_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hdl/cs2sph_pkg.sv
hdl/cs2sph_cordic.sv
hdl/cs2sph_isqrt.sv
hdl/cartesian_to_spherical_convert_core.sv
tb/spherical_result_monitor.sv
tb/tb_cartesian_to_spherical_convert_core.sv
